// File: hw/rtl/mgtc_pkg.sv
// ----------------------------------------------------------------------------
// mgtc_pkg
// Shared types, register indexes and helpers of the mains/generator
// transfer controller.
// ----------------------------------------------------------------------------
package mgtc_pkg;

    localparam int LEVEL_BITS = 17;
    localparam int TIMER_BITS = 8;
    localparam int TICK_W     = 6;
    localparam int RETRY_W    = 2;
    localparam int HOLD_W     = 7;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;
    localparam int LEN_W      = (TIMER_BITS > 9) ? TIMER_BITS : 9;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_THRESHOLD   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SWITCH_DELAY      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CRANK_BASE        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CRANK_STEP        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CRANK_RETRIES     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE            = 3'd5;

    // sequence phases
    localparam logic [1:0] PH_NORMAL = 2'd0;
    localparam logic [1:0] PH_CRANK  = 2'd1;
    localparam logic [1:0] PH_SETTLE = 2'd2;

    typedef struct packed {
        logic [LEVEL_BITS-1:0] mains_level;
        logic [LEVEL_BITS-1:0] generator_level;
        logic                  button_pressed;
    } t_in_item;

    typedef struct packed {
        logic mains_present_lamp;
        logic generator_present_lamp;
        logic auto_lamp;
        logic generator_run;
        logic crank_relay;
        logic load_on_generator;
    } t_out_item;

    typedef struct packed {
        logic [LEVEL_BITS-1:0] level_threshold;
        logic [TICK_W-1:0]     switch_delay_ticks;
        logic [TICK_W-1:0]     crank_base_ticks;
        logic [TICK_W-1:0]     crank_step_ticks;
        logic [RETRY_W-1:0]    crank_retries;
        logic [TICK_W-1:0]     settle_ticks;
    } t_cfg;

    // Timer load for a crank: length minus one, zero length counts as one,
    // saturated to the timer range.
    function automatic logic [TIMER_BITS-1:0] crank_load(
        input logic [TICK_W-1:0]  base,
        input logic [TICK_W-1:0]  step,
        input logic [RETRY_W-1:0] att
    );
        logic [LEN_W-1:0] len;
        logic [LEN_W-1:0] last;
        len  = LEN_W'(base) + LEN_W'(step) * LEN_W'(att);
        last = (len == '0) ? '0 : len - LEN_W'(1);
        if (last > LEN_W'({TIMER_BITS{1'b1}})) begin
            return {TIMER_BITS{1'b1}};
        end
        return TIMER_BITS'(last);
    endfunction

endpackage

// File: hw/rtl/mgtc_cfg.sv
// ----------------------------------------------------------------------------
// mgtc_cfg
// Configuration register bank, written by index, reset to defaults.
// ----------------------------------------------------------------------------
module mgtc_cfg
    import mgtc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_LEVEL_THRESHOLD:   n_cfg.level_threshold    = LEVEL_BITS'(i_cfg_data);
                CFG_SWITCH_DELAY:      n_cfg.switch_delay_ticks = i_cfg_data[TICK_W-1:0];
                CFG_CRANK_BASE:        n_cfg.crank_base_ticks   = i_cfg_data[TICK_W-1:0];
                CFG_CRANK_STEP:        n_cfg.crank_step_ticks   = i_cfg_data[TICK_W-1:0];
                CFG_CRANK_RETRIES:     n_cfg.crank_retries      = i_cfg_data[RETRY_W-1:0];
                CFG_SETTLE:            n_cfg.settle_ticks       = i_cfg_data[TICK_W-1:0];
                default:               n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.level_threshold    <= LEVEL_BITS'(15000);
            r_cfg.switch_delay_ticks <= TICK_W'(20);
            r_cfg.crank_base_ticks   <= TICK_W'(6);
            r_cfg.crank_step_ticks   <= TICK_W'(3);
            r_cfg.crank_retries      <= RETRY_W'(3);
            r_cfg.settle_ticks       <= TICK_W'(40);
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: hw/rtl/mgtc_core.sv
// ----------------------------------------------------------------------------
// mgtc_core
// Controller state and the per-tick update: level compare, button edge,
// run/stop hold counting, crank/settle sequence and load transfer.
// ----------------------------------------------------------------------------
module mgtc_core
    import mgtc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_advance,
    input  t_in_item  i_item,
    input  t_cfg      i_cfg,
    output t_out_item o_result
);

    logic                  r_auto_enabled,     n_auto_enabled;
    logic                  r_button_before,    n_button_before;
    logic                  r_run_commanded,    n_run_commanded;
    logic                  r_start_tried,      n_start_tried;
    logic                  r_load_transferred, n_load_transferred;
    logic [HOLD_W-1:0]     r_hold_count,       n_hold_count;
    logic [1:0]            r_phase,            n_phase;
    logic [RETRY_W-1:0]    r_attempt,          n_attempt;
    logic [TIMER_BITS-1:0] r_phase_timer,      n_phase_timer;
    logic                  r_mains_seen,       n_mains_seen;
    logic                  r_generator_seen,   n_generator_seen;

    logic                  btn_edge;
    logic                  mains_on;
    logic                  gen_on;
    logic                  crank;
    logic                  in_seq;
    logic [TIMER_BITS-1:0] settle_load;

    assign btn_edge = i_item.button_pressed & ~r_button_before;
    assign mains_on = i_item.mains_level > i_cfg.level_threshold;
    assign gen_on   = i_item.generator_level > i_cfg.level_threshold;
    assign settle_load = (i_cfg.settle_ticks == '0) ? TIMER_BITS'(1)
                                                    : TIMER_BITS'(i_cfg.settle_ticks);

    always_comb begin
        n_auto_enabled     = r_auto_enabled;
        n_button_before    = i_item.button_pressed;
        n_run_commanded    = r_run_commanded;
        n_start_tried      = r_start_tried;
        n_load_transferred = r_load_transferred;
        n_hold_count       = r_hold_count;
        n_phase            = r_phase;
        n_attempt          = r_attempt;
        n_phase_timer      = r_phase_timer;
        n_mains_seen       = r_mains_seen;
        n_generator_seen   = r_generator_seen;
        crank              = 1'b0;
        in_seq             = 1'b1;

        // crank phase: count down, then hand over to settle on the same tick
        if (r_phase == PH_CRANK) begin
            if (r_phase_timer != '0) begin
                n_phase_timer = r_phase_timer - TIMER_BITS'(1);
                crank         = 1'b1;
            end else begin
                n_phase       = PH_SETTLE;
                n_phase_timer = settle_load;
            end
        end

        if (n_phase == PH_SETTLE && !crank) begin
            n_mains_seen     = mains_on;
            n_generator_seen = gen_on;
            n_phase_timer    = n_phase_timer - TIMER_BITS'(1);
            if (n_phase_timer == '0) begin
                if (gen_on || mains_on ||
                    ({1'b0, r_attempt} + 3'd1) >= {1'b0, i_cfg.crank_retries}) begin
                    n_phase       = PH_NORMAL;
                    n_attempt     = '0;
                    n_start_tried = 1'b1;
                    n_hold_count  = '0;
                end else begin
                    n_attempt     = r_attempt + RETRY_W'(1);
                    n_phase       = PH_CRANK;
                    n_phase_timer = crank_load(i_cfg.crank_base_ticks,
                                               i_cfg.crank_step_ticks, n_attempt);
                    crank         = 1'b1;
                end
            end
        end else if (n_phase != PH_CRANK) begin
            n_phase          = PH_NORMAL;
            in_seq           = 1'b0;
            n_mains_seen     = mains_on;
            n_generator_seen = gen_on;
            if (btn_edge) begin
                n_auto_enabled = ~r_auto_enabled;
            end
            // drop the load from a dead generator first
            if (!gen_on) begin
                n_load_transferred = 1'b0;
            end

            if (mains_on) begin
                if (gen_on || r_run_commanded) begin
                    n_hold_count = r_hold_count + HOLD_W'(1);
                    if (n_hold_count > HOLD_W'(i_cfg.switch_delay_ticks)) begin
                        n_run_commanded = 1'b0;
                        n_start_tried   = 1'b0;
                        n_hold_count    = '0;
                    end
                end else begin
                    n_hold_count = '0;
                end
            end else if (!r_run_commanded) begin
                n_hold_count = r_hold_count + HOLD_W'(1);
                if (n_hold_count > HOLD_W'(i_cfg.switch_delay_ticks)) begin
                    n_run_commanded = 1'b1;
                    n_hold_count    = '0;
                end
            end else if (n_auto_enabled && !r_start_tried) begin
                n_hold_count = '0;
                in_seq       = 1'b1;
                if (gen_on || i_cfg.crank_retries == '0) begin
                    n_start_tried = 1'b1;
                end else begin
                    n_attempt     = '0;
                    n_phase       = PH_CRANK;
                    n_phase_timer = crank_load(i_cfg.crank_base_ticks,
                                               i_cfg.crank_step_ticks, '0);
                    crank         = 1'b1;
                end
            end else if (gen_on && !n_load_transferred) begin
                n_load_transferred = 1'b1;
                n_hold_count       = '0;
            end else begin
                n_hold_count = '0;
            end
        end
    end

    always_comb begin
        o_result.mains_present_lamp     = n_mains_seen;
        o_result.generator_present_lamp = n_generator_seen;
        o_result.auto_lamp              = (in_seq && n_phase != PH_NORMAL) ? crank
                                                                           : n_auto_enabled;
        o_result.generator_run          = n_run_commanded;
        o_result.crank_relay            = crank;
        o_result.load_on_generator      = n_load_transferred;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_auto_enabled     <= 1'b0;
            r_button_before    <= 1'b0;
            r_run_commanded    <= 1'b0;
            r_start_tried      <= 1'b0;
            r_load_transferred <= 1'b0;
            r_hold_count       <= '0;
            r_phase            <= PH_NORMAL;
            r_attempt          <= '0;
            r_phase_timer      <= '0;
            r_mains_seen       <= 1'b0;
            r_generator_seen   <= 1'b0;
        end else if (i_advance) begin
            r_auto_enabled     <= n_auto_enabled;
            r_button_before    <= n_button_before;
            r_run_commanded    <= n_run_commanded;
            r_start_tried      <= n_start_tried;
            r_load_transferred <= n_load_transferred;
            r_hold_count       <= n_hold_count;
            r_phase            <= n_phase;
            r_attempt          <= n_attempt;
            r_phase_timer      <= n_phase_timer;
            r_mains_seen       <= n_mains_seen;
            r_generator_seen   <= n_generator_seen;
        end
    end

    // a cranking tick always leaves the sequence in crank phase
    a_crank_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_advance && crank |=> r_phase == PH_CRANK)
        else $error("crank relay on without crank phase");

    // attempts never reach the unused top code
    a_attempt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_attempt != 2'd3)
        else $error("attempt counter out of range");

    // load is only on the generator while the generator lamp is lit
    a_load_needs_gen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_load_transferred |-> r_generator_seen)
        else $error("load transferred to an absent generator");

    // state moves only when an item is processed
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_advance |=> $stable(r_phase) && $stable(r_hold_count) && $stable(r_phase_timer))
        else $error("controller state changed without an item");

endmodule

// File: hw/rtl/mains_generator_transfer_control_top.sv
// Pipeline: an item accepted into the input register moves through the core
// into the result register once that register is free or draining (two
// register stages: input register, result register).
// Throughput: one item per cycle while the output is not stalled; the
// per-tick update is a single pass of compare and counter logic between
// the two registers. Reset (i_rst_n low, synchronous): controller state
// cleared, registers back to their defaults, both pipeline stages emptied.
// ----------------------------------------------------------------------------
// mains_generator_transfer_control_top
// Automatic transfer switch controller with valid/stall item channels and a
// configuration write port.
// ----------------------------------------------------------------------------
module mains_generator_transfer_control_top
    import mgtc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_data
);

    t_cfg      cfg;
    t_out_item result;
    logic      advance;
    logic      in_accept;

    logic      r_in_valid,  n_in_valid;
    t_in_item  r_in_item;
    logic      r_out_valid, n_out_valid;
    t_out_item r_out_item;

    mgtc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    mgtc_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_item    (r_in_item),
        .i_cfg     (cfg),
        .o_result  (result)
    );

    // advance the held item whenever the result register is free or draining
    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_accept  = i_in_valid && !o_in_stall;

    always_comb begin
        n_in_valid = r_in_valid;
        if (in_accept) begin
            n_in_valid = 1'b1;
        end else if (advance) begin
            n_in_valid = 1'b0;
        end
        n_out_valid = r_out_valid;
        if (advance) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_item <= i_in_data;
        end
        if (advance) begin
            r_out_item <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_item;

endmodule

// File: test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the mains/generator transfer controller. A model
// of the controller state runs beside the block, predicts the lamp and relay
// outputs of every tick, and checks each result in order. Directed ticks
// cover level extremes, the threshold edge and short start sequences; random
// mains and generator outages follow under several register settings,
// with bursts of idle on both channels and one long output hold-off.
// ----------------------------------------------------------------------------
module tb;
    import mgtc_pkg::*;

    localparam int unsigned           LEVEL_MAX   = (1 << LEVEL_BITS) - 1;
    localparam int                    CYCLE_LIMIT = 400000;
    localparam int                    HOLD_OFF    = 80;
    localparam logic [CFG_IDX_W-1:0]  CFG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0]  CFG_SPARE_B = 3'd7;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_stall;
    t_in_item              in_item;
    logic                  out_valid;
    logic                  out_stall;
    t_out_item             out_item;

    // controller model
    t_cfg                  reg_cfg;
    logic                  auto_on;
    logic                  btn_prev;
    logic                  run_cmd;
    logic                  start_done;
    logic                  load_xfer;
    logic [HOLD_W-1:0]     hold_cnt;
    logic [1:0]            seq_phase;
    logic [RETRY_W-1:0]    crank_try;
    logic [TIMER_BITS-1:0] phase_tmr;
    logic                  lamp_mains;
    logic                  lamp_gen;

    t_out_item             pending_relays[$];
    t_out_item             want;
    int                    mismatch_cnt = 0;
    int                    results_seen = 0;
    int                    cycle_cnt    = 0;
    bit                    idle_on      = 1'b1;
    bit                    hold_off_req = 1'b0;

    mains_generator_transfer_control_top i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_item)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("tb failed");
            $finish;
        end
    end

    function automatic void reset_model();
        reg_cfg.level_threshold    = 17'd15000;
        reg_cfg.switch_delay_ticks = 6'd20;
        reg_cfg.crank_base_ticks   = 6'd6;
        reg_cfg.crank_step_ticks   = 6'd3;
        reg_cfg.crank_retries      = 2'd3;
        reg_cfg.settle_ticks       = 6'd40;
        auto_on    = 1'b0;
        btn_prev   = 1'b0;
        run_cmd    = 1'b0;
        start_done = 1'b0;
        load_xfer  = 1'b0;
        hold_cnt   = '0;
        seq_phase  = PH_NORMAL;
        crank_try  = '0;
        phase_tmr  = '0;
        lamp_mains = 1'b0;
        lamp_gen   = 1'b0;
    endfunction

    // Load the crank timer for the current attempt; this tick is its first.
    function automatic void load_crank_timer();
        int len;
        len = int'(reg_cfg.crank_base_ticks)
            + int'(reg_cfg.crank_step_ticks) * int'(crank_try);
        if (len == 0) len = 1;
        if (len - 1 > (1 << TIMER_BITS) - 1) len = 1 << TIMER_BITS;
        seq_phase = PH_CRANK;
        phase_tmr = TIMER_BITS'(len - 1);
    endfunction

    function automatic t_out_item ats_predict(t_in_item it);
        logic      press;
        logic      mains_on;
        logic      gen_on;
        logic      crank;
        logic      in_seq;
        t_out_item r;
        press    = it.button_pressed && !btn_prev;
        mains_on = it.mains_level > reg_cfg.level_threshold;
        gen_on   = it.generator_level > reg_cfg.level_threshold;
        crank    = 1'b0;
        in_seq   = 1'b1;
        btn_prev = it.button_pressed;

        if (seq_phase == PH_CRANK) begin
            if (phase_tmr != '0) begin
                phase_tmr = phase_tmr - 1'b1;
                crank     = 1'b1;
            end else begin
                seq_phase = PH_SETTLE;
                phase_tmr = (reg_cfg.settle_ticks == '0) ? TIMER_BITS'(1)
                                                          : TIMER_BITS'(reg_cfg.settle_ticks);
            end
        end

        if (seq_phase == PH_SETTLE && !crank) begin
            lamp_mains = mains_on;
            lamp_gen   = gen_on;
            phase_tmr  = phase_tmr - 1'b1;
            if (phase_tmr == '0) begin
                if (gen_on || mains_on
                        || int'(crank_try) + 1 >= int'(reg_cfg.crank_retries)) begin
                    seq_phase  = PH_NORMAL;
                    crank_try  = '0;
                    start_done = 1'b1;
                    hold_cnt   = '0;
                end else begin
                    crank_try = crank_try + 1'b1;
                    load_crank_timer();
                    crank = 1'b1;
                end
            end
        end else if (seq_phase != PH_CRANK) begin
            seq_phase  = PH_NORMAL;
            in_seq     = 1'b0;
            if (press) auto_on = !auto_on;
            lamp_mains = mains_on;
            lamp_gen   = gen_on;
            if (!gen_on) load_xfer = 1'b0;

            if (mains_on) begin
                if (gen_on || run_cmd) begin
                    hold_cnt = hold_cnt + 1'b1;
                    if (hold_cnt > reg_cfg.switch_delay_ticks) begin
                        run_cmd    = 1'b0;
                        start_done = 1'b0;
                        hold_cnt   = '0;
                    end
                end else begin
                    hold_cnt = '0;
                end
            end else if (!run_cmd) begin
                hold_cnt = hold_cnt + 1'b1;
                if (hold_cnt > reg_cfg.switch_delay_ticks) begin
                    run_cmd  = 1'b1;
                    hold_cnt = '0;
                end
            end else if (auto_on && !start_done) begin
                hold_cnt = '0;
                in_seq   = 1'b1;
                if (gen_on || reg_cfg.crank_retries == '0) begin
                    start_done = 1'b1;
                end else begin
                    crank_try = '0;
                    load_crank_timer();
                    crank = 1'b1;
                end
            end else if (gen_on && !load_xfer) begin
                load_xfer = 1'b1;
                hold_cnt  = '0;
            end else begin
                hold_cnt = '0;
            end
        end

        r.mains_present_lamp     = lamp_mains;
        r.generator_present_lamp = lamp_gen;
        r.auto_lamp              = (in_seq && seq_phase != PH_NORMAL) ? crank : auto_on;
        r.generator_run          = run_cmd;
        r.crank_relay            = crank;
        r.load_on_generator      = load_xfer;
        return r;
    endfunction

    // Offer one tick, hold it until taken, then queue its expected outputs.
    task automatic send_tick(t_in_item it);
        int gap;
        gap = (idle_on && $urandom_range(0, 4) == 0) ? $urandom_range(1, 12) : 0;
        @(negedge clk);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge clk); while (in_stall);
        pending_relays.push_back(ats_predict(it));
    endtask

    task automatic send_levels(int unsigned mains, int unsigned gen, bit btn);
        t_in_item it;
        it.mains_level     = LEVEL_BITS'(mains);
        it.generator_level = LEVEL_BITS'(gen);
        it.button_pressed  = btn;
        send_tick(it);
    endtask

    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_relays.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            CFG_LEVEL_THRESHOLD:   reg_cfg.level_threshold    = data;
            CFG_SWITCH_DELAY:      reg_cfg.switch_delay_ticks = TICK_W'(data);
            CFG_CRANK_BASE:        reg_cfg.crank_base_ticks   = TICK_W'(data);
            CFG_CRANK_STEP:        reg_cfg.crank_step_ticks   = TICK_W'(data);
            CFG_CRANK_RETRIES:     reg_cfg.crank_retries      = RETRY_W'(data);
            CFG_SETTLE:            reg_cfg.settle_ticks       = TICK_W'(data);
            default: ;
        endcase
    endtask

    // Random upper bits above a narrow field; the block must mask them off.
    function automatic logic [CFG_DATA_W-1:0] with_junk(int keep, int value);
        return (CFG_DATA_W'($urandom) << keep) | CFG_DATA_W'(value);
    endfunction

    task automatic apply_cfg(t_cfg c);
        write_reg(CFG_LEVEL_THRESHOLD, c.level_threshold);
        write_reg(CFG_SWITCH_DELAY,  with_junk(TICK_W, c.switch_delay_ticks));
        write_reg(CFG_CRANK_BASE,    with_junk(TICK_W, c.crank_base_ticks));
        write_reg(CFG_CRANK_STEP,    with_junk(TICK_W, c.crank_step_ticks));
        write_reg(CFG_CRANK_RETRIES, with_junk(RETRY_W, c.crank_retries));
        write_reg(CFG_SETTLE,        with_junk(TICK_W, c.settle_ticks));
        write_reg(($urandom_range(0, 1) != 0) ? CFG_SPARE_A : CFG_SPARE_B,
                  CFG_DATA_W'($urandom));
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic t_cfg quick_cfg();
        t_cfg c;
        c.level_threshold    = LEVEL_BITS'($urandom);
        c.switch_delay_ticks = TICK_W'($urandom_range(0, 6));
        c.crank_base_ticks   = TICK_W'($urandom_range(0, 5));
        c.crank_step_ticks   = TICK_W'($urandom_range(0, 4));
        c.crank_retries      = RETRY_W'($urandom_range(0, 3));
        c.settle_ticks       = TICK_W'($urandom_range(0, 8));
        return c;
    endfunction

    function automatic logic [LEVEL_BITS-1:0] level_for(bit present);
        int unsigned thr;
        thr = reg_cfg.level_threshold;
        if (present && thr == LEVEL_MAX) return LEVEL_BITS'($urandom);
        case ($urandom_range(0, 3))
            0:       return present ? LEVEL_BITS'(thr + 1) : LEVEL_BITS'(thr);
            1:       return present ? LEVEL_BITS'(LEVEL_MAX) : '0;
            default: return present ? LEVEL_BITS'($urandom_range(thr + 1, LEVEL_MAX))
                                    : LEVEL_BITS'($urandom_range(0, thr));
        endcase
    endfunction

    // Outages and recoveries of random length, with the odd noisy stretch.
    task automatic run_outages(int n_ticks);
        int       left;
        int       seg_len;
        int       seg_max;
        int       press_left;
        bit       mains_up;
        bit       gen_up;
        bit       noisy;
        t_in_item it;
        left       = n_ticks;
        press_left = 0;
        while (left > 0) begin
            seg_max = 2 * (int'(reg_cfg.switch_delay_ticks) + int'(reg_cfg.settle_ticks)
                    + int'(reg_cfg.crank_base_ticks)) + 6;
            seg_len = $urandom_range(1, seg_max);
            if (seg_len > left) seg_len = left;
            mains_up = ($urandom_range(0, 2) == 0);
            gen_up   = ($urandom_range(0, 1) == 0);
            noisy    = ($urandom_range(0, 9) == 0);
            repeat (seg_len) begin
                if ($urandom_range(0, 11) == 0) gen_up = !gen_up;
                if (noisy) begin
                    it.mains_level     = LEVEL_BITS'($urandom);
                    it.generator_level = LEVEL_BITS'($urandom);
                end else begin
                    it.mains_level     = level_for(mains_up);
                    it.generator_level = level_for(gen_up);
                end
                // favor turning auto-start on so start sequences run
                if (press_left == 0 && (!auto_on ? $urandom_range(0, 3) == 0
                                                 : $urandom_range(0, 29) == 0))
                    press_left = $urandom_range(1, 3);
                it.button_pressed = (press_left != 0);
                if (press_left != 0) press_left--;
                send_tick(it);
            end
            left -= seg_len;
        end
    endtask

    task automatic test_level_extremes();
        send_levels(0, 0, 1'b0);
        send_levels(LEVEL_MAX, LEVEL_MAX, 1'b1);
        send_levels(LEVEL_MAX, LEVEL_MAX, 1'b1);
        send_levels(0, 0, 1'b0);
        send_levels(15000, 15000, 1'b0);
        send_levels(15001, 15001, 1'b1);
        send_levels(17'h15555, 17'h0AAAA, 1'b0);
        send_levels(17'h0AAAA, 17'h15555, 1'b0);
        wait_idle();
    endtask

    task automatic test_start_sequences();
        t_cfg c;
        c.level_threshold    = 17'd15000;
        c.switch_delay_ticks = '0;
        c.crank_base_ticks   = '0;
        c.crank_step_ticks   = 6'd2;
        c.crank_retries      = 2'd2;
        c.settle_ticks       = '0;
        apply_cfg(c);
        // two cranks, the first of zero length, zero settle, button ignored while cranking
        send_levels(0, 0, 1'b1);
        send_levels(0, 0, 1'b1);
        send_levels(0, 0, 1'b0);
        send_levels(LEVEL_MAX, LEVEL_MAX, 1'b1);
        send_levels(0, 0, 1'b0);
        send_levels(0, LEVEL_MAX, 1'b0);
        send_levels(0, 0, 1'b0);
        send_levels(LEVEL_MAX, LEVEL_MAX, 1'b0);
        // generator already up when the start comes
        send_levels(0, LEVEL_MAX, 1'b0);
        send_levels(0, LEVEL_MAX, 1'b0);
        send_levels(0, LEVEL_MAX, 1'b0);
        send_levels(LEVEL_MAX, 0, 1'b0);
        wait_idle();
        c.crank_retries = '0;
        apply_cfg(c);
        send_levels(0, 0, 1'b0);
        send_levels(0, 0, 1'b0);
        wait_idle();
    endtask

    task automatic test_default_settings();
        t_cfg c;
        c.level_threshold    = 17'd15000;
        c.switch_delay_ticks = 6'd20;
        c.crank_base_ticks   = 6'd6;
        c.crank_step_ticks   = 6'd3;
        c.crank_retries      = 2'd3;
        c.settle_ticks       = 6'd40;
        apply_cfg(c);
        run_outages(100);
        wait_idle();
    endtask

    task automatic test_quick_settings();
        for (int round = 0; round < 5; round++) begin
            apply_cfg(quick_cfg());
            if (round == 0) hold_off_req = 1'b1;
            run_outages(60);
            wait_idle();
        end
    endtask

    task automatic test_extreme_settings();
        t_cfg c;
        c.level_threshold    = '0;
        c.switch_delay_ticks = '1;
        c.crank_base_ticks   = '1;
        c.crank_step_ticks   = '1;
        c.crank_retries      = '1;
        c.settle_ticks       = '1;
        apply_cfg(c);
        run_outages(80);
        wait_idle();
        c.level_threshold    = '1;
        c.switch_delay_ticks = '0;
        c.crank_base_ticks   = 6'd1;
        c.crank_step_ticks   = '0;
        c.settle_ticks       = 6'd1;
        apply_cfg(c);
        run_outages(40);
        wait_idle();
    endtask

    task automatic test_steady_flow();
        idle_on = 1'b0;
        apply_cfg(quick_cfg());
        run_outages(60);
        wait_idle();
    endtask

    // Output stall: random bursts, plus one long hold-off on request.
    initial begin
        int stall_cnt;
        stall_cnt = 0;
        out_stall = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                stall_cnt    = HOLD_OFF;
            end else if (stall_cnt == 0 && idle_on && $urandom_range(0, 5) == 0) begin
                stall_cnt = $urandom_range(1, 12);
            end
            out_stall <= (stall_cnt != 0);
            if (stall_cnt != 0) stall_cnt--;
        end
    end

    always @(posedge clk) begin
        if (rst_n && out_valid === 1'b1 && !out_stall) begin
            results_seen++;
            if (pending_relays.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("result %0d: none expected, got %b", results_seen, out_item);
            end else begin
                want = pending_relays.pop_front();
                if (want.mains_present_lamp !== out_item.mains_present_lamp
                        || want.generator_present_lamp !== out_item.generator_present_lamp
                        || want.auto_lamp !== out_item.auto_lamp
                        || want.generator_run !== out_item.generator_run
                        || want.crank_relay !== out_item.crank_relay
                        || want.load_on_generator !== out_item.load_on_generator) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display({"result %0d exp/act: mains %b/%b gen %b/%b auto %b/%b ",
                                  "run %b/%b crank %b/%b load %b/%b"}, results_seen,
                                 want.mains_present_lamp, out_item.mains_present_lamp,
                                 want.generator_present_lamp, out_item.generator_present_lamp,
                                 want.auto_lamp, out_item.auto_lamp,
                                 want.generator_run, out_item.generator_run,
                                 want.crank_relay, out_item.crank_relay,
                                 want.load_on_generator, out_item.load_on_generator);
                end
            end
        end
    end

    initial begin
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        in_valid  = 1'b0;
        in_item   = '0;
        reset_model();
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        test_level_extremes();
        test_start_sequences();
        test_default_settings();
        test_quick_settings();
        test_extreme_settings();
        test_steady_flow();

        repeat (8) @(posedge clk);
        if (pending_relays.size() != 0) mismatch_cnt++;
        if (mismatch_cnt == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule

// File: mains_generator_transfer_control_top.f
hw/rtl/mgtc_pkg.sv
hw/rtl/mgtc_cfg.sv
hw/rtl/mgtc_core.sv
hw/rtl/mains_generator_transfer_control_top.sv
test/tb.sv
